// ===== sv/wmjc_pkg.sv =====
// package: shared constants, controller states and command/status types
package wmjc_pkg;

  localparam int MAX_JUMP_DEF    = 16;
  localparam int HEIGHT_BITS_DEF = 16;
  localparam int COST_W          = 32;
  localparam int LIMIT_W         = 5;

  localparam logic [COST_W-1:0]  COST_MAX    = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic issue;   // read one window entry
    logic commit;  // write back the stone and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;      // no jump source for the stone on the input
    logic issue_last;  // the current read is the last window entry
    logic out_free;    // output register can take a result
  } status_t;

endpackage

// ===== sv/wmjc_if.sv =====
// channel interfaces: stone input, cost output and configuration write
interface wmjc_in_if #(
  parameter int HEIGHT_BITS = wmjc_pkg::HEIGHT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [HEIGHT_BITS-1:0] height;
  logic                   first_stone;
  logic                   last_stone;

  modport source (output valid, output height, output first_stone, output last_stone,
                  input ready);
  modport sink   (input valid, input height, input first_stone, input last_stone,
                  output ready);
endinterface

interface wmjc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wmjc_pkg::COST_W-1:0] cost;
  logic                        is_final;

  modport source (output valid, output cost, output is_final, input ready);
  modport sink   (input valid, input cost, input is_final, output ready);
endinterface

interface wmjc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wmjc_pkg::LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/window_min_jump_cost.sv =====
// top level: least-cost frog jump over a stream of stone heights
//
// Each stone beat yields one cost beat: the least total cost to reach that stone by jumps
// of 1 to jump_limit stones back within the current sequence, a jump costing the absolute
// height difference and the sequence's first stone costing zero; costs saturate at
// 2^32-1 and is_final echoes last_stone. A stone with n jump sources, n the smaller of
// the stones seen so far in its sequence and the clamped jump_limit, occupies the block
// through these steps: take the beat; make n reads of the window memory through its
// single read port and take in the last read (both skipped when n is zero); write the
// stone back and load the output register. That last step waits for as long as the
// output register still holds a cost that has not been taken. The next stone is taken
// while a finished cost waits in the output register. jump_limit 0 acts as 1, above
// MAX_JUMP as MAX_JUMP; a stone after a final stone starts a new sequence.
module window_min_jump_cost #(
  parameter int MAX_JUMP    = wmjc_pkg::MAX_JUMP_DEF,
  parameter int HEIGHT_BITS = wmjc_pkg::HEIGHT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wmjc_in_if.sink   in_if,
  wmjc_out_if.source out_if,
  wmjc_cfg_if.sink  cfg_if
);

  wmjc_pkg::cmd_t    cmd;
  wmjc_pkg::status_t status;

  // configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  // controller
  wmjc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  wmjc_dpath #(
    .MAX_JUMP    (MAX_JUMP),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_height      (in_if.height),
    .in_first_stone (in_if.first_stone),
    .in_last_stone  (in_if.last_stone),
    .cfg_valid      (cfg_if.valid),
    .cfg_data       (cfg_if.data),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_cost       (out_if.cost),
    .out_is_final   (out_if.is_final)
  );

endmodule

// ===== sv/wmjc_ctrl.sv =====
// controller: sequences accept, window scan, drain and commit of one stone
module wmjc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wmjc_pkg::status_t status,
  output wmjc_pkg::cmd_t    cmd
);

  wmjc_pkg::state_t state_r;
  wmjc_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmjc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      wmjc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.n_zero ? wmjc_pkg::ST_COMMIT : wmjc_pkg::ST_SCAN;
        end
      end
      wmjc_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = wmjc_pkg::ST_DRAIN;
        end
      end
      wmjc_pkg::ST_DRAIN: begin
        state_nxt = wmjc_pkg::ST_COMMIT;
      end
      wmjc_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = wmjc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmjc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/wmjc_dpath.sv =====
// datapath: window memory, min accumulator, fill count, limit register, output register
module wmjc_dpath #(
  parameter int MAX_JUMP    = wmjc_pkg::MAX_JUMP_DEF,
  parameter int HEIGHT_BITS = wmjc_pkg::HEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wmjc_pkg::cmd_t                cmd,
  output wmjc_pkg::status_t             status,
  input  logic [HEIGHT_BITS-1:0]        in_height,
  input  logic                          in_first_stone,
  input  logic                          in_last_stone,
  input  logic                          cfg_valid,
  input  logic [wmjc_pkg::LIMIT_W-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wmjc_pkg::COST_W-1:0]   out_cost,
  output logic                          out_is_final
);

  localparam int PTR_W  = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
  localparam int FILL_W = $clog2(MAX_JUMP + 1);
  localparam int CMP_W  = FILL_W + wmjc_pkg::LIMIT_W;
  localparam int ADDR_W = PTR_W + 2;
  localparam int CW     = wmjc_pkg::COST_W;
  localparam int MEM_W  = HEIGHT_BITS + CW;

  // window memory: newest entry sits just below the write pointer
  logic [MEM_W-1:0] mem [MAX_JUMP];

  logic [wmjc_pkg::LIMIT_W-1:0] lim_r;
  logic [HEIGHT_BITS-1:0]       height_r;
  logic                         last_r;
  logic [FILL_W-1:0]            n_r;
  logic [FILL_W-1:0]            issue_r;
  logic [PTR_W-1:0]             wp_r;
  logic [FILL_W-1:0]            fill_r;
  logic [MEM_W-1:0]             rd_data_r;
  logic                         rd_vld_r;
  logic [CW-1:0]                min_r;
  logic                         out_valid_r;
  logic [CW-1:0]                out_cost_r;
  logic                         out_final_r;

  logic [CMP_W-1:0]       lim_ext;
  logic [FILL_W-1:0]      eff_lim;
  logic [FILL_W-1:0]      fill_base;
  logic [FILL_W-1:0]      n_now;
  logic [ADDR_W-1:0]      addr_sum;
  logic [ADDR_W-1:0]      addr_red;
  logic [PTR_W-1:0]       rd_addr;
  logic [HEIGHT_BITS-1:0] rd_height;
  logic [CW-1:0]          rd_cost;
  logic [HEIGHT_BITS-1:0] hdiff;
  logic [CW:0]            cand_sum;
  logic [CW-1:0]          cand;

  // effective jump limit, clamped to 1..MAX_JUMP
  assign lim_ext = {{FILL_W{1'b0}}, lim_r};
  always_comb begin
    if (lim_r == '0) begin
      eff_lim = FILL_W'(1);
    end else if (lim_ext > CMP_W'(MAX_JUMP)) begin
      eff_lim = FILL_W'(MAX_JUMP);
    end else begin
      eff_lim = lim_ext[FILL_W-1:0];
    end
  end

  // number of jump sources for the stone on the input
  assign fill_base = in_first_stone ? '0 : fill_r;
  assign n_now     = (fill_base < eff_lim) ? fill_base : eff_lim;

  assign status.n_zero     = (n_now == '0);
  assign status.issue_last = ((issue_r + FILL_W'(1)) == n_r);
  assign status.out_free   = !out_valid_r || out_ready;

  // read address: entry issue_r back from the newest, wrapped
  assign addr_sum = ADDR_W'(wp_r) + ADDR_W'(MAX_JUMP - 1) - ADDR_W'(issue_r);
  assign addr_red = (addr_sum >= ADDR_W'(MAX_JUMP)) ? addr_sum - ADDR_W'(MAX_JUMP)
                                                    : addr_sum;
  assign rd_addr  = addr_red[PTR_W-1:0];

  // candidate cost from the entry read last cycle, saturating
  assign rd_height = rd_data_r[MEM_W-1:CW];
  assign rd_cost   = rd_data_r[CW-1:0];
  assign hdiff     = (height_r >= rd_height) ? height_r - rd_height : rd_height - height_r;
  assign cand_sum  = {1'b0, rd_cost} + (CW+1)'(hdiff);
  assign cand      = cand_sum[CW] ? wmjc_pkg::COST_MAX : cand_sum[CW-1:0];

  // window memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[wp_r] <= {height_r, min_r};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r       <= wmjc_pkg::LIMIT_RESET;
      fill_r      <= '0;
      wp_r        <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lim_r <= cfg_data;
      end
      rd_vld_r <= cmd.issue;
      if (cmd.accept) begin
        fill_r  <= fill_base;
        issue_r <= '0;
      end else if (cmd.issue) begin
        issue_r <= issue_r + FILL_W'(1);
      end
      if (cmd.commit) begin
        wp_r <= (wp_r == PTR_W'(MAX_JUMP - 1)) ? '0 : wp_r + PTR_W'(1);
        if (last_r) begin
          fill_r <= '0;
        end else if (fill_r < FILL_W'(MAX_JUMP)) begin
          fill_r <= fill_r + FILL_W'(1);
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      height_r <= in_height;
      last_r   <= in_last_stone;
      n_r      <= n_now;
      min_r    <= (n_now == '0) ? '0 : wmjc_pkg::COST_MAX;
    end else if (rd_vld_r && (cand < min_r)) begin
      min_r <= cand;
    end
    if (cmd.commit) begin
      out_cost_r  <= min_r;
      out_final_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cost     = out_cost_r;
  assign out_is_final = out_final_r;

endmodule
